### rtl/tmlg_pkg.sv
`default_nettype none
package tmlg_pkg;

  localparam logic [2:0] CL_PLAIN  = 3'd0;
  localparam logic [2:0] CL_BC     = 3'd1;
  localparam logic [2:0] CL_PACKED = 3'd2;
  localparam logic [2:0] CL_PLANAR = 3'd3;
  localparam logic [2:0] CL_NV11   = 3'd4;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEPTH  = 3'd2;
  localparam logic [2:0] REG_MIPS   = 3'd3;
  localparam logic [2:0] REG_LAYERS = 3'd4;
  localparam logic [2:0] REG_FORMAT = 3'd5;

  localparam logic [47:0] OFFSET_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [32:0] SLICE_MAX  = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic [2:0] cls;
    logic [4:0] bpe;
    logic [7:0] bpp;
  } fmt_info_t;

  function automatic logic [7:0] bits_per_pixel(input logic [7:0] f);
    logic [7:0] r;
    r = 8'd0;
    if (f >= 8'd1 && f <= 8'd4) r = 8'd128;
    else if (f >= 8'd5 && f <= 8'd8) r = 8'd96;
    else if (f >= 8'd9 && f <= 8'd22) r = 8'd64;
    else if (f >= 8'd23 && f <= 8'd47) r = 8'd32;
    else if (f >= 8'd48 && f <= 8'd59) r = 8'd16;
    else if (f >= 8'd60 && f <= 8'd65) r = 8'd8;
    else if (f == 8'd66) r = 8'd1;
    else if (f >= 8'd67 && f <= 8'd69) r = 8'd32;
    else if (f >= 8'd85 && f <= 8'd86) r = 8'd16;
    else if (f >= 8'd87 && f <= 8'd93) r = 8'd32;
    else if (f == 8'd100 || f == 8'd101 || f == 8'd107) r = 8'd32;
    else if (f == 8'd102 || f == 8'd108 || f == 8'd109) r = 8'd64;
    else if (f == 8'd103 || f == 8'd106 || f == 8'd110) r = 8'd12;
    else if (f == 8'd104 || f == 8'd105) r = 8'd24;
    else if (f >= 8'd111 && f <= 8'd113) r = 8'd8;
    else if (f == 8'd114 || f == 8'd115) r = 8'd16;
    return r;
  endfunction

  function automatic fmt_info_t format_info(input logic [7:0] f);
    fmt_info_t r;
    r.bpp = bits_per_pixel(f);
    r.cls = CL_PLAIN;
    r.bpe = 5'd0;
    if ((f >= 8'd70 && f <= 8'd72) || (f >= 8'd79 && f <= 8'd81)) begin
      r.cls = CL_BC; r.bpe = 5'd8;
    end else if ((f >= 8'd73 && f <= 8'd78) || (f >= 8'd82 && f <= 8'd84) ||
                 (f >= 8'd94 && f <= 8'd99)) begin
      r.cls = CL_BC; r.bpe = 5'd16;
    end else if (f == 8'd68 || f == 8'd69 || f == 8'd107) begin
      r.cls = CL_PACKED; r.bpe = 5'd4;
    end else if (f == 8'd108 || f == 8'd109) begin
      r.cls = CL_PACKED; r.bpe = 5'd8;
    end else if (f == 8'd103 || f == 8'd106) begin
      r.cls = CL_PLANAR; r.bpe = 5'd2;
    end else if (f == 8'd104 || f == 8'd105) begin
      r.cls = CL_PLANAR; r.bpe = 5'd4;
    end else if (f == 8'd110) begin
      r.cls = CL_NV11;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/texture_mip_layout_generator.sv
`default_nettype none
// Texture subresource layout walker. Each accepted beat (restart selects a return to the first
// subresource) yields one descriptor: byte offset, row pitch, slice pitch, mip, layer and a last
// flag, then the walk advances with layers outer and mips inner and wraps after the last one.
// Acceptance leads through the states ROW, SL, DEP and ADV (RST first when restart is set) to
// OUT, where the result is valid, because the pitches and the offset advance go one after
// another through a single registered 32x16 multiplier. The next beat is accepted in the cycle
// after the result leaves; a stalled result holds the input off. A configuration write to an
// index up to the format register, taken only while idle, restarts the walk.
module texture_mip_layout_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      byte_offset,
  output logic [18:0]      row_pitch,
  output logic [32:0]      slice_pitch,
  output logic [3:0]       mip_index,
  output logic [10:0]      layer_index,
  output logic             last
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_SL   = 3'd2;
  localparam logic [2:0] S_DEP  = 3'd3;
  localparam logic [2:0] S_ADV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_RST  = 3'd6;

  logic [14:0] base_width, base_height, level_width, level_height;
  logic [11:0] base_depth, array_layers, level_depth;
  logic [3:0]  mip_levels, mip_counter;
  logic [7:0]  format_code;
  logic [10:0] layer_counter;
  logic [47:0] running_offset;
  logic [2:0]  state;
  logic [32:0] slice;
  logic [47:0] prod;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic        is_last, mip_end;
  tmlg_pkg::fmt_info_t fi;

  tmlg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  assign fi = tmlg_pkg::format_info(format_code);
  assign in_stall = (state != S_IDLE) || cfg_we;

  logic [15:0] w_half, w_quad, h_blk;
  logic [33:0] nb_sat;
  assign w_half = ({1'b0, level_width} + 16'd1) >> 1;
  assign w_quad = ({1'b0, level_width} + 16'd3) >> 2;
  assign h_blk  = ({1'b0, level_height} + 16'd3) >> 2;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 16'd0;
    case (state)
      S_IDLE, S_RST: begin
        case (fi.cls)
          tmlg_pkg::CL_BC: begin
            mul_a = {16'd0, w_quad}; mul_b = {11'd0, fi.bpe};
          end
          tmlg_pkg::CL_PACKED, tmlg_pkg::CL_PLANAR: begin
            mul_a = {16'd0, w_half}; mul_b = {11'd0, fi.bpe};
          end
          tmlg_pkg::CL_NV11: begin
            mul_a = {16'd0, w_quad}; mul_b = 16'd4;
          end
          default: begin
            mul_a = {17'd0, level_width}; mul_b = {8'd0, fi.bpp};
          end
        endcase
      end
      S_ROW: begin
        mul_a = prod[31:0];
        if (fi.cls == tmlg_pkg::CL_BC) mul_b = h_blk;
        else mul_b = {1'b0, level_height};
        if (fi.cls == tmlg_pkg::CL_PLAIN) mul_a = (prod[31:0] + 32'd7) >> 3;
      end
      S_DEP: begin
        mul_a = slice[31:0];
        mul_b = {4'd0, level_depth};
      end
      default: ;
    endcase
  end

  always_comb begin
    nb_sat = prod[33:0];
    case (fi.cls)
      tmlg_pkg::CL_NV11:   nb_sat = {1'b0, prod[32:0]} << 1;
      tmlg_pkg::CL_PLANAR: nb_sat = {1'b0, prod[32:0]} + ({1'b0, prod[32:0]} + 34'd1 >> 1);
      default:             nb_sat = prod[33:0];
    endcase
  end

  logic [47:0] adv;
  logic [48:0] offs_sum;
  assign adv = prod + (slice[32] ? {4'd0, level_depth, 32'd0} : 48'd0);
  assign offs_sum = {1'b0, running_offset} + {1'b0, adv};

  logic [3:0]  mips_eff;
  logic [11:0] layers_eff;
  always_comb begin
    mips_eff = (mip_levels == 4'd0) ? 4'd1 : mip_levels;
    layers_eff = (array_layers == 12'd0) ? 12'd1 :
                 (array_layers > 12'd2048) ? 12'd2048 : array_layers;
    mip_end = ({1'b0, mip_counter} + 5'd1) >= {1'b0, mips_eff};
    is_last = mip_end && (({1'b0, layer_counter} + 12'd1) >= layers_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      base_width <= 15'd1; base_height <= 15'd1; base_depth <= 12'd1;
      mip_levels <= 4'd1; array_layers <= 12'd1; format_code <= 8'd0;
      level_width <= 15'd1; level_height <= 15'd1; level_depth <= 12'd1;
      mip_counter <= 4'd0; layer_counter <= 11'd0; running_offset <= 48'd0;
    end else if (cfg_we && state == S_IDLE) begin
      case (cfg_index)
        tmlg_pkg::REG_WIDTH:  base_width <= cfg_data;
        tmlg_pkg::REG_HEIGHT: base_height <= cfg_data;
        tmlg_pkg::REG_DEPTH:  base_depth <= cfg_data[11:0];
        tmlg_pkg::REG_MIPS:   mip_levels <= cfg_data[3:0];
        tmlg_pkg::REG_LAYERS: array_layers <= cfg_data[11:0];
        tmlg_pkg::REG_FORMAT: format_code <= cfg_data[7:0];
        default: ;
      endcase
      if (cfg_index <= tmlg_pkg::REG_FORMAT) begin
        level_width <= (cfg_index == tmlg_pkg::REG_WIDTH) ? cfg_data : base_width;
        level_height <= (cfg_index == tmlg_pkg::REG_HEIGHT) ? cfg_data : base_height;
        level_depth <= (cfg_index == tmlg_pkg::REG_DEPTH) ? cfg_data[11:0] : base_depth;
        mip_counter <= 4'd0; layer_counter <= 11'd0; running_offset <= 48'd0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && restart) begin
            level_width <= base_width; level_height <= base_height;
            level_depth <= base_depth; mip_counter <= 4'd0;
            layer_counter <= 11'd0; running_offset <= 48'd0;
            state <= S_RST;
          end else if (in_valid) begin
            state <= S_ROW;
          end
        end
        S_RST: state <= S_ROW;
        S_ROW: begin
          if (fi.cls == tmlg_pkg::CL_PLAIN) row_pitch <= prod[21:3] + {18'd0, |prod[2:0]};
          else row_pitch <= prod[18:0];
          state <= S_SL;
        end
        S_SL: begin
          slice <= (nb_sat > {1'b0, tmlg_pkg::SLICE_MAX}) ? tmlg_pkg::SLICE_MAX : nb_sat[32:0];
          state <= S_DEP;
        end
        S_DEP: state <= S_ADV;
        S_ADV: begin
          byte_offset <= running_offset; slice_pitch <= slice;
          mip_index <= mip_counter; layer_index <= layer_counter; last <= is_last;
          running_offset <= offs_sum[48] ? tmlg_pkg::OFFSET_MAX : offs_sum[47:0];
          if (is_last) begin
            level_width <= base_width; level_height <= base_height;
            level_depth <= base_depth; mip_counter <= 4'd0;
            layer_counter <= 11'd0; running_offset <= 48'd0;
          end else if (mip_end) begin
            level_width <= base_width; level_height <= base_height;
            level_depth <= base_depth; mip_counter <= 4'd0;
            layer_counter <= layer_counter + 11'd1;
          end else begin
            mip_counter <= mip_counter + 4'd1;
            level_width <= (level_width > 15'd1) ? level_width >> 1 : 15'd1;
            level_height <= (level_height > 15'd1) ? level_height >> 1 : 15'd1;
            level_depth <= (level_depth > 12'd1) ? level_depth >> 1 : 12'd1;
          end
          out_valid <= 1'b1; state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/tmlg_mul.sv
`default_nettype none
module tmlg_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [15:0] b,
  output logic [47:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

### dv/texture_mip_layout_generator_tb.sv
`default_nettype none
module texture_mip_layout_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [47:0] offset;
    logic [18:0] row;
    logic [32:0] slice;
    logic [3:0]  mip;
    logic [10:0] layer;
    logic        fin;
  } layout_t;

  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [14:0] data;
    bit          rs;
    bit          lit;
    layout_t     res;
  } step_t;

  localparam layout_t NONE = '0;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic in_valid = 0, restart = 0, out_stall = 0;
  logic in_stall, out_valid, last;
  logic [47:0] byte_offset;
  logic [18:0] row_pitch;
  logic [32:0] slice_pitch;
  logic [3:0] mip_index;
  logic [10:0] layer_index;

  texture_mip_layout_generator uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  logic [14:0] r_width, r_height;
  logic [11:0] r_depth, r_layers;
  logic [3:0]  r_mips;
  logic [7:0]  r_format;
  logic [14:0] lvl_w, lvl_h;
  logic [11:0] lvl_d;
  logic [3:0]  mip_cnt;
  logic [10:0] layer_cnt;
  logic [47:0] run_off;

  layout_t pending_layouts[$];
  int errors = 0;
  bit quiet = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] pixel_bits(logic [7:0] f);
    case (f) inside
      [1:4]: return 128;
      [5:8]: return 96;
      [9:22]: return 64;
      [23:47], [67:69], [87:93], 100, 101, 107: return 32;
      [48:59], 85, 86, 114, 115: return 16;
      [60:65], [111:113]: return 8;
      66: return 1;
      102, 108, 109: return 64;
      103, 106, 110: return 12;
      104, 105: return 24;
      default: return 0;
    endcase
  endfunction

  function automatic void restart_walk();
    lvl_w = r_width; lvl_h = r_height; lvl_d = r_depth;
    mip_cnt = 0; layer_cnt = 0; run_off = 0;
  endfunction

  function automatic layout_t predict_layout(bit rs);
    logic [63:0] w, h, rb, nb, bpe, adv;
    logic [2:0] cls;
    int mips, layers;
    bit mip_end;
    layout_t r;
    mips = (r_mips == 0) ? 1 : r_mips;
    layers = (r_layers == 0) ? 1 : (r_layers > 2048 ? 2048 : r_layers);
    if (rs) restart_walk();
    w = lvl_w; h = lvl_h;
    bpe = 0;
    cls = tmlg_pkg::CL_PLAIN;
    case (r_format) inside
      [70:72], [79:81]: begin cls = tmlg_pkg::CL_BC; bpe = 8; end
      [73:78], [82:84], [94:99]: begin cls = tmlg_pkg::CL_BC; bpe = 16; end
      68, 69, 107: begin cls = tmlg_pkg::CL_PACKED; bpe = 4; end
      108, 109: begin cls = tmlg_pkg::CL_PACKED; bpe = 8; end
      103, 106: begin cls = tmlg_pkg::CL_PLANAR; bpe = 2; end
      104, 105: begin cls = tmlg_pkg::CL_PLANAR; bpe = 4; end
      110: cls = tmlg_pkg::CL_NV11;
      default: ;
    endcase
    case (cls)
      tmlg_pkg::CL_BC: begin
        rb = ((w + 3) / 4) * bpe;
        nb = rb * ((h + 3) / 4);
      end
      tmlg_pkg::CL_PACKED: begin
        rb = ((w + 1) >> 1) * bpe;
        nb = rb * h;
      end
      tmlg_pkg::CL_NV11: begin
        rb = ((w + 3) >> 2) * 4;
        nb = rb * h * 2;
      end
      tmlg_pkg::CL_PLANAR: begin
        rb = ((w + 1) >> 1) * bpe;
        nb = rb * h + ((rb * h + 1) >> 1);
      end
      default: begin
        rb = (w * pixel_bits(r_format) + 7) / 8;
        nb = rb * h;
      end
    endcase
    mip_end = (mip_cnt + 1 >= mips);
    r.offset = run_off;
    r.row = rb[18:0];
    r.slice = (nb > 64'(tmlg_pkg::SLICE_MAX)) ? tmlg_pkg::SLICE_MAX : nb[32:0];
    r.mip = mip_cnt;
    r.layer = layer_cnt;
    r.fin = mip_end && (layer_cnt + 1 >= layers);
    adv = 64'(r.slice) * lvl_d;
    if (adv > 64'(tmlg_pkg::OFFSET_MAX - run_off)) run_off = tmlg_pkg::OFFSET_MAX;
    else run_off = run_off + adv[47:0];
    if (r.fin) restart_walk();
    else if (mip_end) begin
      lvl_w = r_width; lvl_h = r_height; lvl_d = r_depth;
      mip_cnt = 0;
      layer_cnt = layer_cnt + 11'd1;
    end else begin
      mip_cnt = mip_cnt + 4'd1;
      lvl_w = (lvl_w >> 1) == 0 ? 15'd1 : lvl_w >> 1;
      lvl_h = (lvl_h >> 1) == 0 ? 15'd1 : lvl_h >> 1;
      lvl_d = (lvl_d >> 1) == 0 ? 12'd1 : lvl_d >> 1;
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [14:0] data);
    while (pending_layouts.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = data;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      tmlg_pkg::REG_WIDTH: r_width = data;
      tmlg_pkg::REG_HEIGHT: r_height = data;
      tmlg_pkg::REG_DEPTH: r_depth = data[11:0];
      tmlg_pkg::REG_MIPS: r_mips = data[3:0];
      tmlg_pkg::REG_LAYERS: r_layers = data[11:0];
      tmlg_pkg::REG_FORMAT: r_format = data[7:0];
      default: ;
    endcase
    restart_walk();
  endtask

  task automatic send_beat(bit rs, bit lit, layout_t res);
    layout_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1; restart = rs;
    do @(posedge clk); while (in_stall);
    p = predict_layout(rs);
    pending_layouts.push_back(lit ? res : p);
    @(negedge clk);
    in_valid = 0;
  endtask

  always @(negedge clk) begin
    if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1;
      idle_cycles <= $urandom_range(1, 12);
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    layout_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_layouts.size() == 0) begin
        $error("result beat with no expectation");
        errors++;
      end else begin
        e = pending_layouts.pop_front();
        if (byte_offset !== e.offset) begin
          $error("byte_offset exp %0d got %0d", e.offset, byte_offset); errors++;
        end
        if (row_pitch !== e.row) begin
          $error("row_pitch exp %0d got %0d", e.row, row_pitch); errors++;
        end
        if (slice_pitch !== e.slice) begin
          $error("slice_pitch exp %0d got %0d", e.slice, slice_pitch); errors++;
        end
        if (mip_index !== e.mip) begin
          $error("mip_index exp %0d got %0d", e.mip, mip_index); errors++;
        end
        if (layer_index !== e.layer) begin
          $error("layer_index exp %0d got %0d", e.layer, layer_index); errors++;
        end
        if (last !== e.fin) begin
          $error("last exp %0d got %0d", e.fin, last); errors++;
        end
      end
    end
  end

  int stuck = 0;
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= 5000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  step_t dir_tbl [28] = '{
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 1, '{48'd0, 19'd0, 33'd0, 4'd0, 11'd0, 1'b1}},
    '{1, tmlg_pkg::REG_FORMAT, 2, 0, 0, NONE},
    '{1, tmlg_pkg::REG_WIDTH, 16384, 0, 0, NONE},
    '{1, tmlg_pkg::REG_HEIGHT, 16384, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 1,
      '{48'd0, 19'd262144, 33'h1_0000_0000, 4'd0, 11'd0, 1'b1}},
    '{1, tmlg_pkg::REG_DEPTH, 2048, 0, 0, NONE},
    '{1, tmlg_pkg::REG_MIPS, 15, 0, 0, NONE},
    '{1, tmlg_pkg::REG_LAYERS, 4095, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 1,
      '{48'd0, 19'd262144, 33'h1_0000_0000, 4'd0, 11'd0, 1'b0}},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 1, 1,
      '{48'd0, 19'd262144, 33'h1_0000_0000, 4'd0, 11'd0, 1'b0}},
    '{1, tmlg_pkg::REG_FORMAT, 71, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 0, NONE},
    '{1, tmlg_pkg::REG_FORMAT, 68, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 0, NONE},
    '{1, tmlg_pkg::REG_FORMAT, 103, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 0, NONE},
    '{1, tmlg_pkg::REG_FORMAT, 110, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 0, NONE},
    '{1, tmlg_pkg::REG_FORMAT, 200, 0, 1, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 1, '{48'd0, 19'd0, 33'd0, 4'd0, 11'd0, 1'b0}},
    '{1, tmlg_pkg::REG_FORMAT, 66, 0, 0, NONE},
    '{1, tmlg_pkg::REG_WIDTH, 0, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 0, NONE},
    '{1, tmlg_pkg::REG_MIPS, 0, 0, 0, NONE},
    '{1, tmlg_pkg::REG_LAYERS, 0, 0, 0, NONE},
    '{0, tmlg_pkg::REG_WIDTH, 0, 0, 0, NONE}
  };

  function automatic logic [14:0] pick(int lo, int hi, int wide);
    if ($urandom_range(0, 7) == 0) return 15'($urandom);
    if ($urandom_range(0, 3) == 0) return 15'($urandom_range(0, wide));
    return 15'($urandom_range(lo, hi));
  endfunction

  initial begin
    r_width = 1; r_height = 1; r_depth = 1; r_mips = 1; r_layers = 1; r_format = 0;
    restart_walk();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      else send_beat(dir_tbl[i].rs, dir_tbl[i].lit, dir_tbl[i].res);
    end
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        write_reg(tmlg_pkg::REG_WIDTH, 16384); write_reg(tmlg_pkg::REG_HEIGHT, 16384);
        write_reg(tmlg_pkg::REG_DEPTH, 2048); write_reg(tmlg_pkg::REG_MIPS, 15);
        write_reg(tmlg_pkg::REG_LAYERS, 2048); write_reg(tmlg_pkg::REG_FORMAT, 2);
      end else if (ph == 1) begin
        write_reg(tmlg_pkg::REG_WIDTH, 1); write_reg(tmlg_pkg::REG_HEIGHT, 1);
        write_reg(tmlg_pkg::REG_DEPTH, 1); write_reg(tmlg_pkg::REG_MIPS, 1);
        write_reg(tmlg_pkg::REG_LAYERS, 1); write_reg(tmlg_pkg::REG_FORMAT, 0);
      end else begin
        write_reg(tmlg_pkg::REG_WIDTH, pick(1, 64, 32767));
        write_reg(tmlg_pkg::REG_HEIGHT, pick(1, 64, 32767));
        write_reg(tmlg_pkg::REG_DEPTH, pick(1, 8, 4095));
        write_reg(tmlg_pkg::REG_MIPS, pick(0, 15, 15));
        write_reg(tmlg_pkg::REG_LAYERS, pick(1, 6, 4095));
        write_reg(tmlg_pkg::REG_FORMAT, pick(0, 115, 255));
      end
      if (ph == 10) quiet = 1;
      for (int n = 0; n < 95; n++) send_beat($urandom_range(0, 9) == 0, 0, NONE);
    end
    while (pending_layouts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
